@@ src/vsl_pkg.sv @@
package vsl_pkg;

  // Component width and fraction bits of the velocity format
  localparam int COMP_WIDTH = 32;
  localparam int FRAC_BITS  = 8;

  // Speed limit register
  localparam int MAX_SPEED_W = 31;
  localparam int SPEED_LIMIT_RESET = 1500;
  localparam logic [MAX_SPEED_W-1:0] MAX_SPEED_RESET =
    MAX_SPEED_W'(SPEED_LIMIT_RESET << FRAC_BITS);

endpackage

@@ src/vsl_isqrt_pipe.sv @@
module vsl_isqrt_pipe #(
  parameter int CW    = vsl_pkg::COMP_WIDTH,
  parameter int TAG_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*CW-1:0]   in_rad,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [CW-1:0]     out_root,
  output logic              out_exact,
  output logic [TAG_W-1:0]  out_tag
);

  localparam int SW = 2 * CW;
  localparam int RW = CW + 2;

  // one result bit per stage, two radicand bits consumed per stage
  logic [CW-1:0]    valid_r;
  logic [SW-1:0]    rad_r  [CW];
  logic [RW-1:0]    rem_r  [CW];
  logic [CW-1:0]    root_r [CW];
  logic [TAG_W-1:0] tag_r  [CW];

  genvar i;
  generate
    for (i = 0; i < CW; i++) begin : g_stage
      logic             p_valid;
      logic [SW-1:0]    p_rad;
      logic [RW-1:0]    p_rem;
      logic [CW-1:0]    p_root;
      logic [TAG_W-1:0] p_tag;
      logic [RW-1:0]    rem_sh;
      logic [RW-1:0]    trial;
      logic             ge;

      if (i == 0) begin : g_first
        assign p_valid = in_valid;
        assign p_rad   = in_rad;
        assign p_rem   = '0;
        assign p_root  = '0;
        assign p_tag   = in_tag;
      end else begin : g_next
        assign p_valid = valid_r[i-1];
        assign p_rad   = rad_r[i-1];
        assign p_rem   = rem_r[i-1];
        assign p_root  = root_r[i-1];
        assign p_tag   = tag_r[i-1];
      end

      always_comb begin
        rem_sh = {p_rem[RW-3:0], p_rad[SW-1 -: 2]};
        trial  = {p_root, 2'b01};
        ge     = (rem_sh >= trial);
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[i] <= 1'b0;
        end else if (en) begin
          valid_r[i] <= p_valid;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[i]  <= p_rad << 2;
          rem_r[i]  <= ge ? (rem_sh - trial) : rem_sh;
          root_r[i] <= {p_root[CW-2:0], ge};
          tag_r[i]  <= p_tag;
        end
      end
    end
  endgenerate

  assign out_valid = valid_r[CW-1];
  assign out_root  = root_r[CW-1];
  assign out_exact = (rem_r[CW-1] == '0);
  assign out_tag   = tag_r[CW-1];

endmodule

@@ src/vsl_div_pipe.sv @@
module vsl_div_pipe #(
  parameter int CW    = vsl_pkg::COMP_WIDTH,
  parameter int LANES = 3,
  parameter int TAG_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][2*CW-1:0]  in_num,
  input  logic [CW:0]                 in_den,
  input  logic [TAG_W-1:0]            in_tag,
  output logic                        out_valid,
  output logic [LANES-1:0][CW-1:0]    out_quo,
  output logic [TAG_W-1:0]            out_tag
);

  localparam int SW = 2 * CW;

  // restoring division, one quotient bit per stage; numerator top half < divisor
  logic [CW-1:0]                valid_r;
  logic [CW:0]                  den_r [CW];
  logic [LANES-1:0][CW:0]       rem_r [CW];
  logic [LANES-1:0][CW-1:0]     lo_r  [CW];
  logic [LANES-1:0][CW-1:0]     quo_r [CW];
  logic [TAG_W-1:0]             tag_r [CW];

  genvar i, l;
  generate
    for (i = 0; i < CW; i++) begin : g_stage
      logic                     p_valid;
      logic [CW:0]              p_den;
      logic [LANES-1:0][CW:0]   p_rem;
      logic [LANES-1:0][CW-1:0] p_lo;
      logic [LANES-1:0][CW-1:0] p_quo;
      logic [TAG_W-1:0]         p_tag;

      if (i == 0) begin : g_first
        assign p_valid = in_valid;
        assign p_den   = in_den;
        assign p_tag   = in_tag;
        for (l = 0; l < LANES; l++) begin : g_init
          assign p_rem[l] = {1'b0, in_num[l][SW-1:CW]};
          assign p_lo[l]  = in_num[l][CW-1:0];
          assign p_quo[l] = '0;
        end
      end else begin : g_next
        assign p_valid = valid_r[i-1];
        assign p_den   = den_r[i-1];
        assign p_rem   = rem_r[i-1];
        assign p_lo    = lo_r[i-1];
        assign p_quo   = quo_r[i-1];
        assign p_tag   = tag_r[i-1];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[i] <= 1'b0;
        end else if (en) begin
          valid_r[i] <= p_valid;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          den_r[i] <= p_den;
          tag_r[i] <= p_tag;
        end
      end

      for (l = 0; l < LANES; l++) begin : g_lane
        logic [CW+1:0] rem_sh;
        logic [CW+1:0] diff;
        logic          ge;

        always_comb begin
          rem_sh = {p_rem[l], p_lo[l][CW-1]};
          diff   = rem_sh - {1'b0, p_den};
          ge     = (rem_sh >= {1'b0, p_den});
        end

        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[i][l] <= ge ? diff[CW:0] : rem_sh[CW:0];
            lo_r[i][l]  <= p_lo[l] << 1;
            quo_r[i][l] <= {p_quo[l][CW-2:0], ge};
          end
        end
      end
    end
  endgenerate

  assign out_valid = valid_r[CW-1];
  assign out_quo   = quo_r[CW-1];
  assign out_tag   = tag_r[CW-1];

endmodule

@@ src/vector_speed_limiter.sv @@
// Velocity magnitude clamp. Each request carries a 3D velocity (signed fixed
// point, COMP_WIDTH bits); if its Euclidean length is below cfg max_speed it
// passes unchanged, otherwise every component is scaled by
// max_speed / ceil(sqrt(x^2+y^2+z^2)), truncated toward zero, and
// out_was_limited is set. A limit of zero clamps everything to the zero
// vector. Fully pipelined: one request per cycle while the skid entry is
// empty; each request passes the input, square and sum registers, the
// square root (one root bit per stage), the limit-check register, the
// divider (one quotient bit per stage) and the output register. A one-entry
// skid behind the output register keeps in_ready high while a result waits;
// in_ready drops only once both hold a result. No state besides the limit;
// change max_speed only while nothing is in flight.
module vector_speed_limiter #(
  parameter int COMP_WIDTH = vsl_pkg::COMP_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COMP_WIDTH-1:0]        in_vel_x,
  input  logic signed [COMP_WIDTH-1:0]        in_vel_y,
  input  logic signed [COMP_WIDTH-1:0]        in_vel_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [COMP_WIDTH-1:0]        out_lim_x,
  output logic signed [COMP_WIDTH-1:0]        out_lim_y,
  output logic signed [COMP_WIDTH-1:0]        out_lim_z,
  output logic                                out_was_limited,
  input  logic                                cfg_wr_en,
  input  logic [vsl_pkg::MAX_SPEED_W-1:0]     cfg_wr_data
);

  localparam int CW    = COMP_WIDTH;
  localparam int SW    = 2 * CW;
  localparam int MSW   = vsl_pkg::MAX_SPEED_W;
  localparam int CMP_W = (CW > MSW) ? CW : MSW;
  localparam int VEC_W = 3 * CW;

  function automatic logic [CW-1:0] abs_val(input logic [CW-1:0] v);
    // most negative value wraps onto 2^(CW-1), which is its true magnitude
    return v[CW-1] ? (~v + 1'b1) : v;
  endfunction

  // ---------------------------------------------------------------- config
  logic [MSW-1:0] max_speed_r;
  logic [CW-1:0]  max_cw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= vsl_pkg::MAX_SPEED_RESET;
    end else if (cfg_wr_en) begin
      max_speed_r <= cfg_wr_data;
    end
  end

  // when clamping, the limit is at most the root, so it fits CW bits
  assign max_cw = CW'(max_speed_r);

  // whole pipeline moves together unless the skid entry is occupied
  logic en;
  logic skid_valid_r;
  assign en       = !skid_valid_r;
  assign in_ready = en;

  // ------------------------------------------------ stage A: input register
  logic               a_valid_r;
  logic [2:0][CW-1:0] a_raw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_raw_r <= {in_vel_z, in_vel_y, in_vel_x};
    end
  end

  // ------------------------------------------------------ stage B: squares
  logic               b_valid_r;
  logic [2:0][CW-1:0] b_raw_r;
  logic [2:0][SW-1:0] b_sq_r;
  logic [2:0][SW-1:0] sq_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_nxt[k] = SW'(abs_val(a_raw_r[k])) * SW'(abs_val(a_raw_r[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_raw_r <= a_raw_r;
      b_sq_r  <= sq_nxt;
    end
  end

  // ---------------------------------------------------- stage C: sum of sq
  // three squares of at most 2^(2CW-2) each never overflow 2CW bits
  logic               c_valid_r;
  logic [2:0][CW-1:0] c_raw_r;
  logic [SW-1:0]      c_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_raw_r <= b_raw_r;
      c_sum_r <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
    end
  end

  // ---------------------------------------------------------- square root
  logic             sq_valid;
  logic [CW-1:0]    sq_root;
  logic             sq_exact;
  logic [VEC_W-1:0] sq_tag;

  vsl_isqrt_pipe #(
    .CW    (CW),
    .TAG_W (VEC_W)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_valid_r),
    .in_rad    (c_sum_r),
    .in_tag    (c_raw_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_exact (sq_exact),
    .out_tag   (sq_tag)
  );

  // ----------------------------- stage D: limit check, divisor, numerators
  logic               d_valid_r;
  logic [2:0][CW-1:0] d_raw_r;
  logic               d_lim_r;
  logic [CW:0]        d_den_r;
  logic [2:0][SW-1:0] d_num_r;
  logic [2:0][CW-1:0] sq_raw;
  logic [2:0][SW-1:0] num_nxt;

  assign sq_raw = sq_tag;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_nxt[k] = SW'(abs_val(sq_raw[k])) * SW'(max_cw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_raw_r <= sq_raw;
      d_lim_r <= !(CMP_W'(sq_root) < CMP_W'(max_speed_r));
      // divisor is ceil(sqrt): round up unless the sum was a perfect square
      d_den_r <= {1'b0, sq_root} + (CW+1)'(!sq_exact);
      d_num_r <= num_nxt;
    end
  end

  // ------------------------------------------------------------- dividers
  logic               dv_valid;
  logic [2:0][CW-1:0] dv_quo;
  logic [VEC_W:0]     dv_tag;
  logic               t_lim;
  logic [2:0][CW-1:0] t_raw;
  logic [2:0][CW-1:0] t_res;

  vsl_div_pipe #(
    .CW    (CW),
    .LANES (3),
    .TAG_W (VEC_W + 1)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_valid_r),
    .in_num    (d_num_r),
    .in_den    (d_den_r),
    .in_tag    ({d_lim_r, d_raw_r}),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_tag   (dv_tag)
  );

  assign t_lim = dv_tag[VEC_W];
  assign t_raw = dv_tag[VEC_W-1:0];

  // pass-through, zero limit, or signed quotient
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!t_lim) begin
        t_res[k] = t_raw[k];
      end else if (max_speed_r == '0) begin
        t_res[k] = '0;
      end else if (t_raw[k][CW-1]) begin
        t_res[k] = ~dv_quo[k] + 1'b1;
      end else begin
        t_res[k] = dv_quo[k];
      end
    end
  end

  // --------------------------------------------- output register and skid
  logic               out_valid_r;
  logic [2:0][CW-1:0] out_res_r;
  logic               out_lim_r;
  logic [2:0][CW-1:0] skid_res_r;
  logic               skid_lim_r;
  logic               tail_go;
  logic               out_free;

  assign tail_go  = en && dv_valid;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // pipeline is held; skid drains into the output register
      out_valid_r  <= 1'b1;
      skid_valid_r <= !out_ready;
    end else begin
      out_valid_r  <= (tail_go && out_free) || (out_valid_r && !out_ready) ||
                      (tail_go && !out_free);
      skid_valid_r <= tail_go && !out_free;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        out_res_r <= skid_res_r;
        out_lim_r <= skid_lim_r;
      end
    end else if (tail_go) begin
      if (out_free) begin
        out_res_r <= t_res;
        out_lim_r <= t_lim;
      end else begin
        skid_res_r <= t_res;
        skid_lim_r <= t_lim;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_lim_x       = out_res_r[0];
  assign out_lim_y       = out_res_r[1];
  assign out_lim_z       = out_res_r[2];
  assign out_was_limited = out_lim_r;

endmodule

@@ src/vsl_checker.sv @@
module vsl_checker #(
  parameter int COMP_WIDTH = vsl_pkg::COMP_WIDTH
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic signed [COMP_WIDTH-1:0]     in_vel_x,
  input logic signed [COMP_WIDTH-1:0]     in_vel_y,
  input logic signed [COMP_WIDTH-1:0]     in_vel_z,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [COMP_WIDTH-1:0]     out_lim_x,
  input logic signed [COMP_WIDTH-1:0]     out_lim_y,
  input logic signed [COMP_WIDTH-1:0]     out_lim_z,
  input logic                             out_was_limited,
  input logic                             cfg_wr_en,
  input logic [vsl_pkg::MAX_SPEED_W-1:0]  cfg_wr_data
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lim_x) &&
    $stable(out_lim_y) && $stable(out_lim_z) && $stable(out_was_limited))
    else $error("result changed while stalled");

  // back-pressure only appears with a result parked at the output
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // skid fills only after a refused result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

endmodule

bind vector_speed_limiter vsl_checker #(.COMP_WIDTH(COMP_WIDTH)) u_vsl_checker (.*);
